// ===== sv/assert_macros.svh =====
// Assertion macros for the timer core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define PIT_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define PIT_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define PIT_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define PIT_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

// ===== sv/pit_pkg.sv =====
package pit_pkg;

    localparam int NUM_COUNTERS = 3;

    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;
    localparam logic [1:0] KIND_GATE  = 2'd3;

    localparam logic [1:0] PORT_CTRL = 2'd3;

    localparam logic [1:0] SEL_READBACK = 2'd3;

    localparam int C_BCD  = 0;
    localparam int C_RWLO = 4;
    localparam int C_RWHI = 5;
    localparam int C_NULL = 6;

    localparam int A_RDLO  = 0;
    localparam int A_WRLO  = 1;
    localparam int A_STOP  = 2;
    localparam int A_GATE  = 3;
    localparam int A_LSTAT = 4;
    localparam int A_LAT0  = 5;
    localparam int A_LAT1  = 6;
    localparam int A_LOAD  = 7;

    localparam logic [16:0] FULL_BIN = 17'd65536;
    localparam logic [16:0] FULL_BCD = 17'd10000;

    typedef struct packed {
        logic [1:0] mode;
        logic [1:0] port;
        logic [7:0] data;
        logic [1:0] gate_index;
        logic       gate_level;
    } pit_in_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic [2:0] out_levels;
        logic       irq_pulse;
    } pit_out_t;

    typedef struct packed {
        logic [6:0]  ctl;
        logic [16:0] cur;
        logic [16:0] rel;
        logic [15:0] pend;
        logic [15:0] lat;
        logic [7:0]  stat;
        logic [7:0]  acc;
        logic        outl;
    } pit_cnt_t;

    localparam pit_cnt_t CNT_RESET = '{
        ctl:  7'd0,
        cur:  17'd0,
        rel:  FULL_BIN,
        pend: 16'd0,
        lat:  16'd0,
        stat: 8'd0,
        acc:  8'((1 << A_STOP) | (1 << A_GATE)),
        outl: 1'b0
    };

    function automatic logic [16:0] bcd_decode(input logic [15:0] r);
        logic [16:0] a;
        a = 17'(r[15:12]) * 17'd1000 + 17'(r[11:8]) * 17'd100
          + 17'(r[7:4]) * 17'd10 + 17'(r[3:0]);
        return a;
    endfunction

    // Digits by reciprocal multiplication, exact for any 17-bit value
    function automatic logic [15:0] bcd_encode(input logic [16:0] v);
        logic [35:0] p1;
        logic [35:0] p2;
        logic [35:0] p3;
        logic [35:0] p4;
        logic [16:0] q1;
        logic [16:0] q2;
        logic [16:0] q3;
        logic [16:0] q4;
        logic [16:0] d0;
        logic [16:0] d1;
        logic [16:0] d2;
        logic [16:0] d3;
        p1 = 36'(v) * 36'd104858;
        p2 = 36'(v) * 36'd167773;
        p3 = 36'(v) * 36'd134218;
        p4 = 36'(v) * 36'd107375;
        q1 = 17'(p1 >> 20);
        q2 = 17'(p2 >> 24);
        q3 = 17'(p3 >> 27);
        q4 = 17'(p4 >> 30);
        d0 = v - q1 * 17'd10;
        d1 = q1 - q2 * 17'd10;
        d2 = q2 - q3 * 17'd10;
        d3 = q3 - q4 * 17'd10;
        return {d3[3:0], d2[3:0], d1[3:0], d0[3:0]};
    endfunction

endpackage

// ===== sv/pit_if.sv =====
interface pit_in_if;
    logic            valid;
    logic            ready;
    pit_pkg::pit_in_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface pit_out_if;
    logic             valid;
    logic             ready;
    pit_pkg::pit_out_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== sv/pit_counter.sv =====
module pit_counter (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  pit_pkg::pit_in_t   item,
    input  logic [1:0]         idx,
    output logic               outl,
    output logic               outl_next,
    output logic [7:0]         rd
);

    pit_pkg::pit_cnt_t s_reg;
    pit_pkg::pit_cnt_t s_next;

    assign outl = s_reg.outl;
    assign outl_next = s_next.outl;

    function automatic pit_pkg::pit_cnt_t take_count(input pit_pkg::pit_cnt_t x);
        logic [16:0] v;
        pit_pkg::pit_cnt_t y;
        y = x;
        v = x.ctl[pit_pkg::C_BCD] ? pit_pkg::bcd_decode(x.pend) : {1'b0, x.pend};
        if (v == 17'd0)
            v = x.ctl[pit_pkg::C_BCD] ? pit_pkg::FULL_BCD : pit_pkg::FULL_BIN;
        y.rel = v;
        y.ctl[pit_pkg::C_NULL] = 1'b0;
        return y;
    endfunction

    function automatic pit_pkg::pit_cnt_t start_count(input pit_pkg::pit_cnt_t x);
        logic [16:0] v;
        pit_pkg::pit_cnt_t y;
        y = x;
        v = x.rel;
        if (x.ctl[3:1] == 3'd3 && v[0])
        begin
            v = x.outl ? v + 17'd1 : v - 17'd1;
            if (v == 17'd0)
                v = 17'd2;
        end
        y.cur = v;
        return y;
    endfunction

    function automatic logic [16:0] dec(input pit_pkg::pit_cnt_t x);
        if (x.cur == 17'd0)
            return x.ctl[pit_pkg::C_BCD] ? 17'd9999 : 17'd65535;
        return x.cur - 17'd1;
    endfunction

    function automatic pit_pkg::pit_cnt_t count_done(input pit_pkg::pit_cnt_t x);
        pit_pkg::pit_cnt_t y;
        y = x;
        y.ctl[pit_pkg::C_NULL] = 1'b1;
        case (x.ctl[3:1])
            3'd0:
            begin
                y.outl = 1'b0;
                y.acc[pit_pkg::A_LOAD] = 1'b1;
            end
            3'd4: y.acc[pit_pkg::A_LOAD] = 1'b1;
            3'd2, 3'd3: if (x.acc[pit_pkg::A_STOP]) y.acc[pit_pkg::A_LOAD] = 1'b1;
            default: ;
        endcase
        return y;
    endfunction

    function automatic pit_pkg::pit_cnt_t latch(input pit_pkg::pit_cnt_t x,
                                                input logic stat, input logic cnt);
        pit_pkg::pit_cnt_t y;
        y = x;
        if (stat && !x.acc[pit_pkg::A_LSTAT])
        begin
            y.stat = {x.outl, x.ctl};
            y.acc[pit_pkg::A_LSTAT] = 1'b1;
        end
        if (cnt && x.acc[pit_pkg::A_LAT1:pit_pkg::A_LAT0] == 2'd0)
        begin
            y.lat = x.cur[15:0];
            y.acc[pit_pkg::A_LAT1:pit_pkg::A_LAT0] = x.ctl[5:4];
        end
        return y;
    endfunction

    always_comb
    begin
        logic [2:0]  m;
        logic [16:0] c;
        logic [15:0] r;
        logic [1:0]  lt;
        logic        gate;
        logic        stop;
        s_next = s_reg;
        rd = 8'd0;
        m = s_reg.ctl[3:1];
        gate = s_reg.acc[pit_pkg::A_GATE];
        stop = s_reg.acc[pit_pkg::A_STOP];
        c = s_reg.cur;
        r = 16'd0;
        lt = s_reg.acc[pit_pkg::A_LAT1:pit_pkg::A_LAT0];
        if (en)
        begin
            case (item.mode)
                pit_pkg::KIND_TICK:
                begin
                    if (s_reg.acc[pit_pkg::A_LOAD])
                    begin
                        s_next.acc[pit_pkg::A_LOAD] = 1'b0;
                        s_next.acc[pit_pkg::A_STOP] = 1'b0;
                        s_next = take_count(s_next);
                        if (m == 3'd1)
                            s_next.outl = 1'b0;
                        s_next = start_count(s_next);
                    end
                    else
                    begin
                        case (m)
                            3'd0:
                                if (!stop && gate)
                                begin
                                    c = dec(s_reg);
                                    if (c == 17'd0) s_next.outl = 1'b1;
                                    s_next.cur = c;
                                end
                            3'd1:
                            begin
                                c = dec(s_reg);
                                s_next.cur = c;
                                if (c == 17'd0 && !stop)
                                begin
                                    s_next.outl = 1'b1;
                                    s_next.acc[pit_pkg::A_STOP] = 1'b1;
                                end
                            end
                            3'd2:
                                if (!stop && gate)
                                begin
                                    if (c <= 17'd1)
                                    begin
                                        s_next.outl = 1'b1;
                                        if (s_next.ctl[pit_pkg::C_NULL] &&
                                            !s_next.acc[pit_pkg::A_WRLO])
                                            s_next = take_count(s_next);
                                        s_next = start_count(s_next);
                                    end
                                    else
                                    begin
                                        c = c - 17'd1;
                                        s_next.cur = c;
                                        if (c == 17'd1) s_next.outl = 1'b0;
                                    end
                                end
                            3'd3:
                                if (!stop && gate)
                                begin
                                    if (c <= 17'd2)
                                    begin
                                        s_next.outl = ~s_reg.outl;
                                        if (s_next.ctl[pit_pkg::C_NULL] &&
                                            !s_next.acc[pit_pkg::A_WRLO])
                                            s_next = take_count(s_next);
                                        s_next = start_count(s_next);
                                    end
                                    else
                                        s_next.cur = c - 17'd2;
                                end
                            default:
                            begin
                                s_next.outl = 1'b1;
                                if (!(m == 3'd4 && !gate))
                                begin
                                    c = dec(s_reg);
                                    s_next.cur = c;
                                    if (c == 17'd0 && !stop)
                                    begin
                                        s_next.outl = 1'b0;
                                        s_next.acc[pit_pkg::A_STOP] = 1'b1;
                                    end
                                end
                            end
                        endcase
                    end
                end
                pit_pkg::KIND_READ:
                begin
                    if (item.port == idx)
                    begin
                        if (s_reg.acc[pit_pkg::A_LSTAT])
                        begin
                            s_next.acc[pit_pkg::A_LSTAT] = 1'b0;
                            rd = s_reg.stat;
                        end
                        else
                        begin
                            if (lt[0])
                            begin
                                r = s_reg.ctl[pit_pkg::C_BCD] ?
                                    pit_pkg::bcd_encode({1'b0, s_reg.lat}) : s_reg.lat;
                                rd = r[7:0];
                                lt = lt - 2'd1;
                            end
                            else if (lt[1])
                            begin
                                r = s_reg.ctl[pit_pkg::C_BCD] ?
                                    pit_pkg::bcd_encode({1'b0, s_reg.lat}) : s_reg.lat;
                                rd = r[15:8];
                                lt = 2'd0;
                            end
                            else
                            begin
                                r = s_reg.ctl[pit_pkg::C_BCD] ?
                                    pit_pkg::bcd_encode(s_reg.cur) : s_reg.cur[15:0];
                                if (s_reg.acc[pit_pkg::A_RDLO])
                                begin
                                    rd = r[15:8];
                                    s_next.acc[pit_pkg::A_RDLO] = 1'b0;
                                end
                                else
                                begin
                                    rd = s_reg.ctl[pit_pkg::C_RWLO] ? r[7:0] : r[15:8];
                                    if (s_reg.ctl[pit_pkg::C_RWLO] &&
                                        s_reg.ctl[pit_pkg::C_RWHI])
                                        s_next.acc[pit_pkg::A_RDLO] = 1'b1;
                                end
                            end
                            s_next.acc[pit_pkg::A_LAT1:pit_pkg::A_LAT0] = lt;
                        end
                    end
                end
                pit_pkg::KIND_WRITE:
                begin
                    if (item.port == idx)
                    begin
                        if (s_reg.acc[pit_pkg::A_WRLO])
                        begin
                            s_next.acc[pit_pkg::A_WRLO] = 1'b0;
                            s_next.pend = {item.data, s_reg.pend[7:0]};
                            s_next = count_done(s_next);
                        end
                        else if (s_reg.ctl[pit_pkg::C_RWLO])
                        begin
                            s_next.pend = {8'd0, item.data};
                            if (s_reg.ctl[pit_pkg::C_RWHI])
                            begin
                                s_next.acc[pit_pkg::A_WRLO] = 1'b1;
                                if (m == 3'd0) s_next.acc[pit_pkg::A_STOP] = 1'b1;
                            end
                            else
                                s_next = count_done(s_next);
                        end
                        else
                        begin
                            s_next.pend = {item.data, 8'd0};
                            s_next = count_done(s_next);
                        end
                    end
                    else if (item.port == pit_pkg::PORT_CTRL)
                    begin
                        if (item.data[7:6] == pit_pkg::SEL_READBACK)
                        begin
                            if (item.data[idx + 2'd1])
                                s_next = latch(s_reg, !item.data[4], !item.data[5]);
                        end
                        else if (item.data[7:6] == idx)
                        begin
                            if (item.data[5:4] == 2'd0)
                                s_next = latch(s_reg, 1'b0, 1'b1);
                            else if (item.data[3:1] <= 3'd5)
                            begin
                                s_next.ctl = {1'b1, item.data[5:0]};
                                s_next.outl = (item.data[3:1] != 3'd0);
                                s_next.acc = 8'd0;
                                s_next.acc[pit_pkg::A_GATE] = gate;
                                s_next.acc[pit_pkg::A_STOP] = 1'b1;
                            end
                        end
                    end
                end
                default:
                begin
                    if (item.gate_index == idx && item.gate_level != gate)
                    begin
                        if (!item.gate_level)
                        begin
                            s_next.acc[pit_pkg::A_GATE] = 1'b0;
                            if (m == 3'd2 || m == 3'd3) s_next.outl = 1'b1;
                        end
                        else
                        begin
                            s_next.acc[pit_pkg::A_GATE] = 1'b1;
                            if (m == 3'd1 || m == 3'd5)
                                s_next.acc[pit_pkg::A_LOAD] = 1'b1;
                            else if ((m == 3'd2 || m == 3'd3) && !stop)
                                s_next.acc[pit_pkg::A_LOAD] = 1'b1;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s_reg <= pit_pkg::CNT_RESET;
        else
            s_reg <= s_next;
    end

endmodule

// ===== sv/programmable_interval_timer_core.sv =====
// A result is registered when its item is accepted and is offered in the next cycle.
// Throughput: one item per cycle; each counter updates in a single pass.
// A waiting result holds off the input until the result is taken.
// Reset (rst_n, async low): counters stopped, gates high, reload 65536,
// out levels low, no result pending.
module programmable_interval_timer_core (
    input  logic clk,
    input  logic rst_n,
    pit_in_if.sink    in_ch,
    pit_out_if.source out_ch
);
`include "assert_macros.svh"

    logic              accept;
    logic [7:0]        rd [pit_pkg::NUM_COUNTERS];
    logic [2:0]        outl;
    logic [2:0]        outl_next;
    logic [7:0]        rd_any;
    logic              res_valid_reg;
    pit_pkg::pit_out_t res_reg;
    pit_pkg::pit_out_t res_next;
    logic              stall;
    logic              irq_ok;

    assign in_ch.ready = !res_valid_reg || out_ch.ready;
    assign accept = in_ch.valid && in_ch.ready;

    for (genvar g = 0; g < pit_pkg::NUM_COUNTERS; g++)
    begin : g_cnt
        pit_counter u_cnt (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (accept),
            .item     (in_ch.payload),
            .idx      (2'(g)),
            .outl     (outl[g]),
            .outl_next(outl_next[g]),
            .rd       (rd[g])
        );
    end

    always_comb
    begin
        rd_any = 8'd0;
        for (int k = 0; k < pit_pkg::NUM_COUNTERS; k++)
            rd_any = rd_any | rd[k];
        res_next.read_data = rd_any;
        res_next.out_levels = outl_next;
        res_next.irq_pulse = !outl[0] && outl_next[0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
            res_reg <= '0;
        end
        else if (accept)
        begin
            res_valid_reg <= 1'b1;
            res_reg <= res_next;
        end
        else if (out_ch.ready)
            res_valid_reg <= 1'b0;
    end

    assign out_ch.valid = res_valid_reg;
    assign out_ch.payload = res_reg;

    assign stall = res_valid_reg && !out_ch.ready;
    assign irq_ok = !res_reg.irq_pulse || res_reg.out_levels[0];

    `PIT_ASSERT_NEXT(a_res_after_accept, clk, rst_n, accept, res_valid_reg, "result lost")
    `PIT_ASSERT_IMPL(a_irq_rise, clk, rst_n, irq_ok, "irq without out0")
    `PIT_ASSERT_NEXT(a_hold, clk, rst_n, stall, res_valid_reg, "result dropped")
    `PIT_ASSERT_NEXT(a_stable, clk, rst_n, stall, $stable(res_reg), "result changed")

endmodule

// ===== dv/tb.sv =====
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_RANDOM = 1500;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;

    typedef struct {
        pit_pkg::pit_in_t  item;
        bit                typed;
        pit_pkg::pit_out_t res;
    } row_t;

    logic clk;
    logic rst_n;

    pit_in_if  in_ch();
    pit_out_if out_ch();

    programmable_interval_timer_core u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    logic [6:0]  ctl_q  [pit_pkg::NUM_COUNTERS];
    logic [16:0] cur_q  [pit_pkg::NUM_COUNTERS];
    logic [16:0] rel_q  [pit_pkg::NUM_COUNTERS];
    logic [15:0] pend_q [pit_pkg::NUM_COUNTERS];
    logic [15:0] lat_q  [pit_pkg::NUM_COUNTERS];
    logic [7:0]  stat_q [pit_pkg::NUM_COUNTERS];
    logic [7:0]  acc_q  [pit_pkg::NUM_COUNTERS];
    logic        outl_q [pit_pkg::NUM_COUNTERS];

    pit_pkg::pit_out_t expected_results[$];
    row_t              offered_rows[$];
    row_t              directed_rows[$];
    int                errors;
    int                idle_cycles;
    int                accepted_items;
    bit                sender_done;

    initial clk = 1'b0;
    always #6 clk = ~clk;

    function automatic logic [2:0] timer_mode(int i);
        return ctl_q[i][3:1];
    endfunction

    function automatic logic [15:0] count_view(int i, logic [16:0] v);
        int x;
        x = int'(v);
        if (ctl_q[i][pit_pkg::C_BCD])
            return 16'(((x / 1000) % 10) << 12 | ((x / 100) % 10) << 8
                       | ((x / 10) % 10) << 4 | (x % 10));
        return v[15:0];
    endfunction

    function automatic void load_reload(int i);
        int v;
        v = int'(pend_q[i]);
        if (ctl_q[i][pit_pkg::C_BCD])
            v = int'(pend_q[i][15:12]) * 1000 + int'(pend_q[i][11:8]) * 100
              + int'(pend_q[i][7:4]) * 10 + int'(pend_q[i][3:0]);
        if (v == 0)
            v = ctl_q[i][pit_pkg::C_BCD] ? int'(pit_pkg::FULL_BCD) : int'(pit_pkg::FULL_BIN);
        rel_q[i] = 17'(v);
        ctl_q[i][pit_pkg::C_NULL] = 1'b0;
    endfunction

    function automatic void restart_count(int i);
        int v;
        v = int'(rel_q[i]);
        if (timer_mode(i) == 3'd3 && v[0])
        begin
            v = outl_q[i] ? v + 1 : v - 1;
            if (v == 0)
                v = 2;
        end
        cur_q[i] = 17'(v);
    endfunction

    function automatic void periodic_reload(int i);
        if (ctl_q[i][pit_pkg::C_NULL] && !acc_q[i][pit_pkg::A_WRLO])
            load_reload(i);
        restart_count(i);
    endfunction

    function automatic logic [16:0] count_down(int i, logic [16:0] c);
        if (c == 17'd0)
            return ctl_q[i][pit_pkg::C_BCD] ? 17'd9999 : 17'd65535;
        return c - 17'd1;
    endfunction

    function automatic void tick_counter(int i);
        logic [2:0]  m;
        logic        gate;
        logic        stop;
        logic [16:0] c;
        m = timer_mode(i);
        gate = acc_q[i][pit_pkg::A_GATE];
        stop = acc_q[i][pit_pkg::A_STOP];
        c = cur_q[i];
        if (acc_q[i][pit_pkg::A_LOAD])
        begin
            acc_q[i][pit_pkg::A_LOAD] = 1'b0;
            acc_q[i][pit_pkg::A_STOP] = 1'b0;
            load_reload(i);
            if (m == 3'd1)
                outl_q[i] = 1'b0;
            restart_count(i);
            return;
        end
        case (m)
            3'd0:
            begin
                if (stop || !gate)
                    return;
                c = count_down(i, c);
                if (c == 17'd0)
                    outl_q[i] = 1'b1;
                cur_q[i] = c;
            end
            3'd1:
            begin
                c = count_down(i, c);
                cur_q[i] = c;
                if (c == 17'd0 && !stop)
                begin
                    outl_q[i] = 1'b1;
                    acc_q[i][pit_pkg::A_STOP] = 1'b1;
                end
            end
            3'd2:
            begin
                if (stop || !gate)
                    return;
                if (c <= 17'd1)
                begin
                    outl_q[i] = 1'b1;
                    periodic_reload(i);
                end
                else
                begin
                    c = c - 17'd1;
                    cur_q[i] = c;
                    if (c == 17'd1)
                        outl_q[i] = 1'b0;
                end
            end
            3'd3:
            begin
                if (stop || !gate)
                    return;
                if (c <= 17'd2)
                begin
                    outl_q[i] = ~outl_q[i];
                    periodic_reload(i);
                end
                else
                    cur_q[i] = c - 17'd2;
            end
            default:
            begin
                outl_q[i] = 1'b1;
                if (m == 3'd4 && !gate)
                    return;
                c = count_down(i, c);
                cur_q[i] = c;
                if (c == 17'd0 && !stop)
                begin
                    outl_q[i] = 1'b0;
                    acc_q[i][pit_pkg::A_STOP] = 1'b1;
                end
            end
        endcase
    endfunction

    function automatic logic [7:0] read_counter(int i);
        logic [7:0]  f;
        logic [1:0]  lc;
        logic [7:0]  v;
        logic [15:0] r;
        f = acc_q[i];
        lc = f[pit_pkg::A_LAT1:pit_pkg::A_LAT0];
        if (f[pit_pkg::A_LSTAT])
        begin
            acc_q[i][pit_pkg::A_LSTAT] = 1'b0;
            return stat_q[i];
        end
        if (lc[0])
        begin
            r = count_view(i, {1'b0, lat_q[i]});
            v = r[7:0];
            lc = lc - 2'd1;
        end
        else if (lc[1])
        begin
            r = count_view(i, {1'b0, lat_q[i]});
            v = r[15:8];
            lc = 2'd0;
        end
        else if (f[pit_pkg::A_RDLO])
        begin
            r = count_view(i, cur_q[i]);
            v = r[15:8];
            f[pit_pkg::A_RDLO] = 1'b0;
        end
        else
        begin
            r = count_view(i, cur_q[i]);
            v = ctl_q[i][pit_pkg::C_RWLO] ? r[7:0] : r[15:8];
            if (ctl_q[i][pit_pkg::C_RWLO] && ctl_q[i][pit_pkg::C_RWHI])
                f[pit_pkg::A_RDLO] = 1'b1;
        end
        f[pit_pkg::A_LAT1:pit_pkg::A_LAT0] = lc;
        acc_q[i] = f;
        return v;
    endfunction

    function automatic void finish_write(int i);
        logic [2:0] m;
        m = timer_mode(i);
        ctl_q[i][pit_pkg::C_NULL] = 1'b1;
        if (m == 3'd0)
        begin
            outl_q[i] = 1'b0;
            acc_q[i][pit_pkg::A_LOAD] = 1'b1;
        end
        else if (m == 3'd4)
            acc_q[i][pit_pkg::A_LOAD] = 1'b1;
        else if ((m == 3'd2 || m == 3'd3) && acc_q[i][pit_pkg::A_STOP])
            acc_q[i][pit_pkg::A_LOAD] = 1'b1;
    endfunction

    function automatic void write_counter(int i, logic [7:0] d);
        if (acc_q[i][pit_pkg::A_WRLO])
        begin
            acc_q[i][pit_pkg::A_WRLO] = 1'b0;
            pend_q[i] = {d, pend_q[i][7:0]};
            finish_write(i);
        end
        else if (ctl_q[i][pit_pkg::C_RWLO])
        begin
            pend_q[i] = {8'd0, d};
            if (ctl_q[i][pit_pkg::C_RWHI])
            begin
                acc_q[i][pit_pkg::A_WRLO] = 1'b1;
                if (timer_mode(i) == 3'd0)
                    acc_q[i][pit_pkg::A_STOP] = 1'b1;
                return;
            end
            finish_write(i);
        end
        else
        begin
            pend_q[i] = {d, 8'd0};
            finish_write(i);
        end
    endfunction

    function automatic void latch_counter(int i, bit status, bit count);
        if (status && !acc_q[i][pit_pkg::A_LSTAT])
        begin
            stat_q[i] = {outl_q[i], ctl_q[i]};
            acc_q[i][pit_pkg::A_LSTAT] = 1'b1;
        end
        if (count && acc_q[i][pit_pkg::A_LAT1:pit_pkg::A_LAT0] == 2'd0)
        begin
            lat_q[i] = cur_q[i][15:0];
            acc_q[i][pit_pkg::A_LAT1:pit_pkg::A_LAT0] =
                ctl_q[i][pit_pkg::C_RWHI:pit_pkg::C_RWLO];
        end
    endfunction

    function automatic void write_control(logic [7:0] d);
        int sel;
        sel = int'(d[7:6]);
        if (d[7:6] == pit_pkg::SEL_READBACK)
        begin
            for (int i = 0; i < pit_pkg::NUM_COUNTERS; i++)
                if (d[i + 1])
                    latch_counter(i, !d[4], !d[5]);
            return;
        end
        if (sel >= pit_pkg::NUM_COUNTERS)
            return;
        if (d[5:4] == 2'd0)
        begin
            latch_counter(sel, 1'b0, 1'b1);
            return;
        end
        if (d[3:1] > 3'd5)
            return;
        ctl_q[sel] = {1'b1, d[5:0]};
        outl_q[sel] = (d[3:1] != 3'd0);
        acc_q[sel] = (acc_q[sel] & (8'd1 << pit_pkg::A_GATE)) | (8'd1 << pit_pkg::A_STOP);
    endfunction

    function automatic void change_gate(int i, logic lvl);
        logic [2:0] m;
        m = timer_mode(i);
        if (lvl == acc_q[i][pit_pkg::A_GATE])
            return;
        if (!lvl)
        begin
            acc_q[i][pit_pkg::A_GATE] = 1'b0;
            if (m == 3'd2 || m == 3'd3)
                outl_q[i] = 1'b1;
            return;
        end
        acc_q[i][pit_pkg::A_GATE] = 1'b1;
        if (m == 3'd1 || m == 3'd5)
            acc_q[i][pit_pkg::A_LOAD] = 1'b1;
        else if ((m == 3'd2 || m == 3'd3) && !acc_q[i][pit_pkg::A_STOP])
            acc_q[i][pit_pkg::A_LOAD] = 1'b1;
    endfunction

    function automatic pit_pkg::pit_out_t timer_step(pit_pkg::pit_in_t it);
        pit_pkg::pit_out_t o;
        logic              old0;
        old0 = outl_q[0];
        o = '0;
        case (it.mode)
            pit_pkg::KIND_TICK:
                for (int i = 0; i < pit_pkg::NUM_COUNTERS; i++)
                    tick_counter(i);
            pit_pkg::KIND_READ:
                if (int'(it.port) < pit_pkg::NUM_COUNTERS)
                    o.read_data = read_counter(int'(it.port));
            pit_pkg::KIND_WRITE:
                if (it.port == pit_pkg::PORT_CTRL)
                    write_control(it.data);
                else if (int'(it.port) < pit_pkg::NUM_COUNTERS)
                    write_counter(int'(it.port), it.data);
            default:
                if (int'(it.gate_index) < pit_pkg::NUM_COUNTERS)
                    change_gate(int'(it.gate_index), it.gate_level);
        endcase
        for (int i = 0; i < pit_pkg::NUM_COUNTERS; i++)
            o.out_levels[i] = outl_q[i];
        o.irq_pulse = !old0 && outl_q[0];
        return o;
    endfunction

    function automatic pit_pkg::pit_in_t item(logic [1:0] k, logic [1:0] p, logic [7:0] d,
                                              logic [1:0] gi, logic gl);
        pit_pkg::pit_in_t it;
        it.mode = k;
        it.port = p;
        it.data = d;
        it.gate_index = gi;
        it.gate_level = gl;
        return it;
    endfunction

    function automatic row_t row(pit_pkg::pit_in_t it, bit typed, pit_pkg::pit_out_t res);
        row_t r;
        r.item = it;
        r.typed = typed;
        r.res = res;
        return r;
    endfunction

    function automatic pit_pkg::pit_in_t random_item();
        pit_pkg::pit_in_t it;
        int               r;
        it = pit_pkg::pit_in_t'(15'($urandom));
        r = $urandom_range(0, 99);
        if (r < 45)
            it.mode = pit_pkg::KIND_TICK;
        else if (r < 60)
            it.mode = pit_pkg::KIND_READ;
        else if (r < 85)
        begin
            it.mode = pit_pkg::KIND_WRITE;
            if (it.port == pit_pkg::PORT_CTRL)
            begin
                if ($urandom_range(0, 3) != 0)
                    it.data[3:1] = 3'($urandom_range(0, 5));
            end
            else if ($urandom_range(0, 3) != 0)
                it.data = 8'($urandom_range(0, 9));
        end
        else
            it.mode = pit_pkg::KIND_GATE;
        return it;
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    initial
    begin
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.payload = '0;
        out_ch.ready = 1'b0;
        errors = 0;
        idle_cycles = 0;
        accepted_items = 0;
        sender_done = 1'b0;
        for (int i = 0; i < pit_pkg::NUM_COUNTERS; i++)
        begin
            ctl_q[i] = '0;
            cur_q[i] = '0;
            rel_q[i] = pit_pkg::FULL_BIN;
            pend_q[i] = '0;
            lat_q[i] = '0;
            stat_q[i] = '0;
            acc_q[i] = (8'd1 << pit_pkg::A_STOP) | (8'd1 << pit_pkg::A_GATE);
            outl_q[i] = 1'b0;
        end
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    initial
    begin
        pit_pkg::pit_in_t it;
        int               gap;
        bit               burst;
        directed_rows.push_back(row(item(pit_pkg::KIND_READ, 2'd0, 8'h00, 2'd0, 1'b0), 1, '0));
        directed_rows.push_back(row(item(pit_pkg::KIND_READ, pit_pkg::PORT_CTRL, 8'hff,
                                         2'd3, 1'b1), 1, '0));
        directed_rows.push_back(row(item(pit_pkg::KIND_WRITE, pit_pkg::PORT_CTRL, 8'h34,
                                         2'd0, 1'b0), 1,
                                    '{read_data: 8'h00, out_levels: 3'b001, irq_pulse: 1'b1}));
        directed_rows.push_back(row(item(pit_pkg::KIND_WRITE, 2'd0, 8'h03, 2'd0, 1'b0), 0, '0));
        directed_rows.push_back(row(item(pit_pkg::KIND_WRITE, 2'd0, 8'h00, 2'd0, 1'b0), 0, '0));
        repeat (5)
            directed_rows.push_back(row(item(pit_pkg::KIND_TICK, 2'd0, 8'h00, 2'd0, 1'b0),
                                        0, '0));
        directed_rows.push_back(row(item(pit_pkg::KIND_WRITE, pit_pkg::PORT_CTRL, 8'h00,
                                         2'd0, 1'b0), 0, '0));
        directed_rows.push_back(row(item(pit_pkg::KIND_READ, 2'd0, 8'h00, 2'd0, 1'b0), 0, '0));
        directed_rows.push_back(row(item(pit_pkg::KIND_READ, 2'd0, 8'h00, 2'd0, 1'b0), 0, '0));
        directed_rows.push_back(row(item(pit_pkg::KIND_WRITE, pit_pkg::PORT_CTRL, 8'h3e,
                                         2'd0, 1'b0), 0, '0));
        directed_rows.push_back(row(item(pit_pkg::KIND_WRITE, pit_pkg::PORT_CTRL, 8'h1b,
                                         2'd0, 1'b0), 0, '0));
        directed_rows.push_back(row(item(pit_pkg::KIND_GATE, 2'd0, 8'h00, 2'd0, 1'b0), 0, '0));
        directed_rows.push_back(row(item(pit_pkg::KIND_GATE, 2'd0, 8'h00, 2'd0, 1'b1), 0, '0));
        directed_rows.push_back(row(item(pit_pkg::KIND_TICK, 2'd0, 8'h00, 2'd0, 1'b0), 0, '0));
        directed_rows.push_back(row(item(pit_pkg::KIND_WRITE, pit_pkg::PORT_CTRL, 8'hc2,
                                         2'd0, 1'b0), 0, '0));
        directed_rows.push_back(row(item(pit_pkg::KIND_READ, 2'd0, 8'h00, 2'd0, 1'b0), 0, '0));
        directed_rows.push_back(row(item(pit_pkg::KIND_READ, 2'd0, 8'h00, 2'd0, 1'b0), 0, '0));
        directed_rows.push_back(row(item(pit_pkg::KIND_WRITE, pit_pkg::PORT_CTRL, 8'h96,
                                         2'd0, 1'b0), 0, '0));
        directed_rows.push_back(row(item(pit_pkg::KIND_WRITE, 2'd2, 8'h01, 2'd0, 1'b0), 0, '0));
        directed_rows.push_back(row(item(pit_pkg::KIND_WRITE, 2'd1, 8'hff, 2'd0, 1'b0), 0, '0));
        directed_rows.push_back(row(item(pit_pkg::KIND_GATE, 2'd0, 8'h00, 2'd3, 1'b0), 0, '0));
        directed_rows.push_back(row(item(pit_pkg::KIND_TICK, 2'd0, 8'h00, 2'd0, 1'b0), 0, '0));
        @(posedge rst_n);
        @(negedge clk);
        burst = 1'b0;
        for (int n = 0; n < directed_rows.size() + N_RANDOM; n++)
        begin
            if (n % 100 == 0)
                burst = ($urandom_range(0, 2) == 0);
            gap = burst ? 0 : gap_len();
            if (gap > 0)
            begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            if (n < directed_rows.size())
                offered_rows.push_back(directed_rows[n]);
            else
            begin
                it = random_item();
                offered_rows.push_back(row(it, 0, '0));
            end
            in_ch.payload <= offered_rows[$].item;
            in_ch.valid <= 1'b1;
            do
                @(posedge clk);
            while (!in_ch.ready);
            @(negedge clk);
        end
        in_ch.valid <= 1'b0;
        sender_done = 1'b1;
    end

    initial
    begin
        bit burst;
        bit held;
        int g;
        @(posedge rst_n);
        held = 1'b0;
        burst = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!held && accepted_items >= 700)
            begin
                held = 1'b1;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            if ($urandom_range(0, 99) == 0)
                burst = ~burst;
            g = gap_len();
            if (burst || g == 0)
                out_ch.ready <= 1'b1;
            else
            begin
                out_ch.ready <= 1'b0;
                repeat (g) @(negedge clk);
                out_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        row_t              r;
        pit_pkg::pit_out_t exp;
        pit_pkg::pit_out_t act;
        if (rst_n && in_ch.valid && in_ch.ready)
        begin
            r = offered_rows.pop_front();
            exp = timer_step(in_ch.payload);
            expected_results.push_back(r.typed ? r.res : exp);
            accepted_items++;
        end
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            act = out_ch.payload;
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result %p", $time, act);
                errors++;
            end
            else
            begin
                exp = expected_results.pop_front();
                if (act.read_data !== exp.read_data)
                begin
                    $display("%0t: read_data expected %h actual %h",
                             $time, exp.read_data, act.read_data);
                    errors++;
                end
                if (act.out_levels !== exp.out_levels)
                begin
                    $display("%0t: out_levels expected %b actual %b",
                             $time, exp.out_levels, act.out_levels);
                    errors++;
                end
                if (act.irq_pulse !== exp.irq_pulse)
                begin
                    $display("%0t: irq_pulse expected %b actual %b",
                             $time, exp.irq_pulse, act.irq_pulse);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("** programmable_interval_timer_core: FAILED **");
            $finish;
        end
    end

    initial
    begin
        wait (sender_done);
        wait (expected_results.size() == 0);
        repeat (5) @(posedge clk);
        if (errors == 0 && expected_results.size() == 0)
            $display("** programmable_interval_timer_core: PASSED **");
        else
            $display("** programmable_interval_timer_core: FAILED **");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/pit_pkg.sv
sv/pit_if.sv
sv/pit_counter.sv
sv/programmable_interval_timer_core.sv
dv/tb.sv
